// File: hw/rtl/sspf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspf_pkg
// Types and constants shared by the swap slot and page fault engine.
// ----------------------------------------------------------------------------
package sspf_pkg;

   localparam int ENTRY_W         = 32;
   localparam int FLAG_W          = 12;
   localparam int PAGE_SHIFT      = 12;
   localparam int BLOCK_W         = ENTRY_W - PAGE_SHIFT;
   localparam int BASE_W          = 16;
   localparam int FREE_WORD_W     = 32;
   localparam int FREE_BIT_W      = 5;

   localparam int SLOT_COUNT_DEF      = 512;
   localparam int BLOCKS_PER_PAGE_DEF = 8;

   localparam int                 CSR_IDX_W        = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_BASE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAPPED_MARK = 1'b1;

   localparam logic [BASE_W-1:0] SWAP_BASE_RST    = 16'd2;
   localparam logic [FLAG_W-1:0] SWAPPED_MARK_RST = 12'd512;

   localparam logic [FLAG_W-1:0] PTE_PRESENT  = 12'h001;
   localparam logic [FLAG_W-1:0] PTE_WRITABLE = 12'h002;

   typedef enum logic [1:0] {
      CMD_SWAP_OUT = 2'd0,
      CMD_FAULT    = 2'd1,
      CMD_RELEASE  = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_COPY  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [ENTRY_W-1:0] entry;
      logic [ENTRY_W-1:0] new_frame;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] new_entry;
      logic [BLOCK_W-1:0] block_no;
      action_type         action;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic               done;
      logic [BLOCK_W-1:0] quotient;
   } div_result_type;

endpackage
`default_nettype wire

// File: hw/rtl/sspf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sspf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/sspf_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspf_divider
// Slot index from a block offset by multiplying with a fixed-point reciprocal
// of the blocks-per-page constant; quotient registered in the cycle after start.
// ----------------------------------------------------------------------------
module sspf_divider #(
   parameter int BLOCKS_PER_PAGE = sspf_pkg::BLOCKS_PER_PAGE_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [sspf_pkg::BLOCK_W-1:0]  dividend,
   output      sspf_pkg::div_result_type      result
);
   import sspf_pkg::*;

   // reciprocal rounded up, exact for every BLOCK_W-bit dividend
   localparam int                 SHIFT_W = BLOCK_W + $clog2(BLOCKS_PER_PAGE);
   localparam int                 RECIP_W = BLOCK_W + 2;
   localparam int                 PROD_W  = BLOCK_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP   =
      RECIP_W'((64'd1 << SHIFT_W) / 64'(BLOCKS_PER_PAGE) + 64'd1);

   logic               done_ff, done_in;
   logic [BLOCK_W-1:0] quot_ff, quot_in;
   logic [PROD_W-1:0]  product;

   always_comb begin
      product = PROD_W'(dividend) * PROD_W'(RECIP);
      done_in = start;
      quot_in = quot_ff;
      if (start) begin
         quot_in = BLOCK_W'(product >> SHIFT_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quot_ff;

endmodule
`default_nettype wire

// File: hw/rtl/swap_slot_page_fault_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swap_slot_page_fault_engine_top
// Swap slot allocator (first fit) with swap-out, page fault and release.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset a clearing pass over every slot frees
// it and zeroes its saved flags; requests wait until it ends.
// A swap-out scans the free bitmap one 32-slot word per cycle until it finds a
// free slot or has read the last word. A fault on a swapped entry or a release
// at or above the swap base takes its slot index from a reciprocal multiply; an
// index beyond the swap area is answered as out of range. Other requests are
// answered from the idle state directly.
// ----------------------------------------------------------------------------
module swap_slot_page_fault_engine_top #(
   parameter int SLOT_COUNT      = sspf_pkg::SLOT_COUNT_DEF,
   parameter int BLOCKS_PER_PAGE = sspf_pkg::BLOCKS_PER_PAGE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire sspf_pkg::req_type               req_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      sspf_pkg::rsp_type               rsp_data,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [sspf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sspf_pkg::BASE_W-1:0]     csr_wdata
);
   import sspf_pkg::*;

   localparam int SLOT_W   = $clog2(SLOT_COUNT);
   localparam int WORD_CNT = (SLOT_COUNT + FREE_WORD_W - 1) / FREE_WORD_W;
   localparam int WADDR_W  = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;
   localparam int TAIL     = SLOT_COUNT % FREE_WORD_W;
   localparam logic [FREE_WORD_W-1:0] LAST_MASK = (TAIL == 0) ? {FREE_WORD_W{1'b1}} :
                                                  FREE_WORD_W'((64'd1 << TAIL) - 64'd1);
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_CNT - 1);
   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [BLOCK_W-1:0] SLOT_LIMIT = BLOCK_W'(SLOT_COUNT);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_BUILD = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_FREE  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   function automatic logic [FREE_BIT_W-1:0] first_set(input logic [FREE_WORD_W-1:0] w);
      logic [FREE_BIT_W-1:0] pos;
      pos = '0;
      for (int i = FREE_WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            pos = FREE_BIT_W'(i);
         end
      end
      return pos;
   endfunction

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  ctr_ff, ctr_in;
   logic [WADDR_W-1:0] ptr_ff, ptr_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [FLAG_W-1:0]  mark_ff, mark_in;

   cmd_type            cmd_ff, cmd_in;
   logic [FLAG_W-1:0]  flags_ff, flags_in;
   logic [BLOCK_W-1:0] frame_ff, frame_in;
   logic [BLOCK_W-1:0] block_ff, block_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   rsp_type            rsp_ff, rsp_in;

   logic                   bm_wr_en, bm_rd_en;
   logic [WADDR_W-1:0]     bm_wr_addr, bm_rd_addr;
   logic [FREE_WORD_W-1:0] bm_wr_data, bm_rd_data;
   logic                   fl_wr_en, fl_rd_en;
   logic [SLOT_W-1:0]      fl_wr_addr, fl_rd_addr;
   logic [FLAG_W-1:0]      fl_wr_data, fl_rd_data;

   logic                   div_start;
   logic [BLOCK_W-1:0]     div_dividend;
   div_result_type         div_res;

   logic [BLOCK_W-1:0]     req_block;
   logic [FREE_WORD_W-1:0] scan_word;
   logic [FREE_BIT_W-1:0]  scan_bit;
   logic [SLOT_W-1:0]      scan_idx;
   logic [BLOCK_W-1:0]     slot_block;

   sspf_ram #(
      .WIDTH (FREE_WORD_W),
      .DEPTH (WORD_CNT),
      .ADDR_W(WADDR_W)
   ) u_free_ram (
      .clock  (clock),
      .wr_en  (bm_wr_en),
      .wr_addr(bm_wr_addr),
      .wr_data(bm_wr_data),
      .rd_en  (bm_rd_en),
      .rd_addr(bm_rd_addr),
      .rd_data(bm_rd_data)
   );

   sspf_ram #(
      .WIDTH (FLAG_W),
      .DEPTH (SLOT_COUNT),
      .ADDR_W(SLOT_W)
   ) u_flags_ram (
      .clock  (clock),
      .wr_en  (fl_wr_en),
      .wr_addr(fl_wr_addr),
      .wr_data(fl_wr_data),
      .rd_en  (fl_rd_en),
      .rd_addr(fl_rd_addr),
      .rd_data(fl_rd_data)
   );

   sspf_divider #(
      .BLOCKS_PER_PAGE(BLOCKS_PER_PAGE)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .result  (div_res)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign req_block    = req_data.entry[ENTRY_W-1:PAGE_SHIFT];
   assign div_dividend = req_block - BLOCK_W'(base_ff);
   assign scan_word    = bm_rd_data & ((ptr_ff == LAST_WORD) ? LAST_MASK : '1);
   assign scan_bit     = first_set(scan_word);
   assign scan_idx     = SLOT_W'({ptr_ff, scan_bit});
   assign slot_block   = BLOCK_W'(32'(base_ff) + 32'(idx_ff) * 32'(BLOCKS_PER_PAGE));

   always_comb begin
      state_in   = state_ff;
      ctr_in     = ctr_ff;
      ptr_in     = ptr_ff;
      base_in    = base_ff;
      mark_in    = mark_ff;
      cmd_in     = cmd_ff;
      flags_in   = flags_ff;
      frame_in   = frame_ff;
      block_in   = block_ff;
      idx_in     = idx_ff;
      rsp_in     = rsp_ff;
      bm_wr_en   = 1'b0;
      bm_wr_addr = '0;
      bm_wr_data = '0;
      bm_rd_en   = 1'b0;
      bm_rd_addr = '0;
      fl_wr_en   = 1'b0;
      fl_wr_addr = '0;
      fl_wr_data = '0;
      fl_rd_en   = 1'b0;
      fl_rd_addr = '0;
      div_start  = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_SWAP_BASE:    base_in = csr_wdata;
            CSR_SWAPPED_MARK: mark_in = csr_wdata[FLAG_W-1:0];
            default:          ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = WADDR_W'(ctr_ff >> FREE_BIT_W);
            bm_wr_data = '1;
            fl_wr_en   = 1'b1;
            fl_wr_addr = ctr_ff;
            fl_wr_data = '0;
            ctr_in     = ctr_ff + 1'b1;
            if (ctr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               flags_in = req_data.entry[FLAG_W-1:0];
               frame_in = req_data.new_frame[ENTRY_W-1:PAGE_SHIFT];
               block_in = req_block;
               rsp_in   = '{new_entry: '0, block_no: '0, action: ACT_NONE, status: ST_OK};
               state_in = S_OUT;
               case (req_data.cmd)
                  CMD_SWAP_OUT: begin
                     bm_rd_en = 1'b1;
                     ptr_in   = '0;
                     state_in = S_SCAN;
                  end
                  CMD_FAULT, CMD_RELEASE: begin
                     if (req_data.cmd == CMD_FAULT && req_data.entry[0]) begin
                        rsp_in.new_entry = {req_data.new_frame[ENTRY_W-1:PAGE_SHIFT],
                                            PTE_PRESENT | PTE_WRITABLE};
                        rsp_in.action    = ACT_COPY;
                     end else if (req_block < BLOCK_W'(base_ff)) begin
                        rsp_in.block_no = req_block;
                        rsp_in.status   = ST_RANGE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (|scan_word) begin
               bm_wr_en   = 1'b1;
               bm_wr_addr = ptr_ff;
               bm_wr_data = bm_rd_data & ~(FREE_WORD_W'(1) << scan_bit);
               fl_wr_en   = 1'b1;
               fl_wr_addr = scan_idx;
               fl_wr_data = flags_ff;
               idx_in     = scan_idx;
               state_in   = S_BUILD;
            end else if (ptr_ff == LAST_WORD) begin
               rsp_in   = '{new_entry: '0, block_no: '0, action: ACT_NONE, status: ST_FULL};
               state_in = S_OUT;
            end else begin
               ptr_in     = ptr_ff + 1'b1;
               bm_rd_en   = 1'b1;
               bm_rd_addr = ptr_ff + 1'b1;
            end
         end
         S_BUILD: begin
            rsp_in.new_entry = {slot_block, mark_ff[FLAG_W-1:1], 1'b0};
            rsp_in.block_no  = slot_block;
            rsp_in.action    = ACT_WRITE;
            rsp_in.status    = ST_OK;
            state_in         = S_OUT;
         end
         S_DIV: begin
            if (div_res.done) begin
               if (div_res.quotient >= SLOT_LIMIT) begin
                  rsp_in.block_no = block_ff;
                  rsp_in.status   = ST_RANGE;
                  state_in        = S_OUT;
               end else begin
                  idx_in     = SLOT_W'(div_res.quotient);
                  bm_rd_en   = 1'b1;
                  bm_rd_addr = WADDR_W'(div_res.quotient >> FREE_BIT_W);
                  fl_rd_en   = 1'b1;
                  fl_rd_addr = SLOT_W'(div_res.quotient);
                  state_in   = S_FREE;
               end
            end
         end
         S_FREE: begin
            bm_wr_en        = 1'b1;
            bm_wr_addr      = WADDR_W'(idx_ff >> FREE_BIT_W);
            bm_wr_data      = bm_rd_data | (FREE_WORD_W'(1) << FREE_BIT_W'(idx_ff));
            rsp_in.block_no = block_ff;
            rsp_in.status   = ST_OK;
            if (cmd_ff == CMD_FAULT) begin
               rsp_in.new_entry = {frame_ff, fl_rd_data | PTE_PRESENT};
               rsp_in.action    = ACT_READ;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ctr_ff   <= '0;
         ptr_ff   <= '0;
         base_ff  <= SWAP_BASE_RST;
         mark_ff  <= SWAPPED_MARK_RST;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
         ptr_ff   <= ptr_in;
         base_ff  <= base_in;
         mark_ff  <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      flags_ff <= flags_in;
      frame_ff <= frame_in;
      block_ff <= block_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

`ifndef SYNTHESIS
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("ready for a request while a response is pending");

   a_full_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
      (rsp_data.new_entry == '0 && rsp_data.block_no == '0 && rsp_data.action == ACT_NONE))
      else $error("swap full response carries data");

   a_range_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_RANGE) |->
      (rsp_data.new_entry == '0 && rsp_data.action == ACT_NONE))
      else $error("out of range response carries an entry or action");
`endif

endmodule
`default_nettype wire

// File: verif/tb_swap_slot_page_fault_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swap_slot_page_fault_engine_top
// Self-checking bench for the swap slot and page fault engine. A short table of
// directed requests is followed by random swap-out, fault and release traffic
// over several swap area settings. Each result is checked against a model of
// the slot table or, for a typed directed row, that row's response. One phase
// fills the swap area until full. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_swap_slot_page_fault_engine_top;
   import sspf_pkg::*;

   localparam int SLOTS           = SLOT_COUNT_DEF;
   localparam int BPP             = BLOCKS_PER_PAGE_DEF;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int FULL_TARGET     = 8;
   localparam int DRAIN_CYCLES    = 40;
   localparam int STALL_LIMIT     = 5000;

   typedef struct packed {
      req_type req;
      bit      check_typed;
      rsp_type rsp;
   } directed_row_type;

   // reset settings: base block 2, swapped mark 0x200
   localparam directed_row_type DIRECTED_ROWS [18] = '{
      '{'{CMD_SWAP_OUT, 32'hFFFFFFFF, 32'h00000000}, 1'b1,
        '{32'h00002200, 20'h00002, ACT_WRITE, ST_OK}},
      '{'{CMD_SWAP_OUT, 32'h00000000, 32'hFFFFFFFF}, 1'b1,
        '{32'h0000A200, 20'h0000A, ACT_WRITE, ST_OK}},
      '{'{CMD_FAULT, 32'h00000001, 32'hFFFFFFFF}, 1'b1,
        '{32'hFFFFF003, 20'h00000, ACT_COPY, ST_OK}},
      '{'{CMD_FAULT, 32'h00002000, 32'h12345FFF}, 1'b1,
        '{32'h12345FFF, 20'h00002, ACT_READ, ST_OK}},
      '{'{CMD_FAULT, 32'h00009FFE, 32'h00000000}, 1'b1,
        '{32'h00000FFF, 20'h00009, ACT_READ, ST_OK}},
      '{'{CMD_RELEASE, 32'h00011000, 32'h00000000}, 1'b1,
        '{32'h00000000, 20'h00011, ACT_NONE, ST_OK}},
      '{'{CMD_RELEASE, 32'h0000A000, 32'h00000000}, 1'b1,
        '{32'h00000000, 20'h0000A, ACT_NONE, ST_OK}},
      '{'{CMD_FAULT, 32'h00001FFE, 32'hFFFFFFFF}, 1'b1,
        '{32'h00000000, 20'h00001, ACT_NONE, ST_RANGE}},
      '{'{CMD_RELEASE, 32'hFFFFF000, 32'h00000000}, 1'b1,
        '{32'h00000000, 20'hFFFFF, ACT_NONE, ST_RANGE}},
      '{'{CMD_RELEASE, 32'h01002000, 32'h00000000}, 1'b1,
        '{32'h00000000, 20'h01002, ACT_NONE, ST_RANGE}},
      '{'{CMD_FAULT, 32'h01001FFE, 32'h00000000}, 1'b1,
        '{32'h00000001, 20'h01001, ACT_READ, ST_OK}},
      '{'{CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
        '{32'h00000000, 20'h00000, ACT_NONE, ST_OK}},
      '{'{CMD_FAULT, 32'hFFFFFFFF, 32'h00000000}, 1'b1,
        '{32'h00000003, 20'h00000, ACT_COPY, ST_OK}},
      '{'{CMD_SWAP_OUT, 32'h12345678, 32'hFFFFFFFF}, 1'b0,
        '{32'h00000000, 20'h00000, ACT_NONE, ST_OK}},
      '{'{CMD_SWAP_OUT, 32'h00000ABC, 32'h00000000}, 1'b0,
        '{32'h00000000, 20'h00000, ACT_NONE, ST_OK}},
      '{'{CMD_FAULT, 32'h00005F0E, 32'h89ABCDEF}, 1'b0,
        '{32'h00000000, 20'h00000, ACT_NONE, ST_OK}},
      '{'{CMD_RELEASE, 32'h0000A123, 32'h00000000}, 1'b0,
        '{32'h00000000, 20'h00000, ACT_NONE, ST_OK}},
      '{'{CMD_FAULT, 32'h5A5A5A5B, 32'hA5A5A5A5}, 1'b0,
        '{32'h00000000, 20'h00000, ACT_NONE, ST_OK}}
   };

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SWAP_BASE;
   logic [BASE_W-1:0]    csr_wdata = '0;

   // model of the slot table and settings
   bit                slot_is_free     [SLOTS] = '{default: 1'b1};
   logic [FLAG_W-1:0] slot_saved_flags [SLOTS] = '{default: '0};
   logic [BASE_W-1:0] cfg_swap_base    = SWAP_BASE_RST;
   logic [FLAG_W-1:0] cfg_swapped_mark = SWAPPED_MARK_RST;

   rsp_type expected_pte_q [$];
   rsp_type oldest_pte;
   int      err_count     = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      stall_cycles  = 0;

   swap_slot_page_fault_engine_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type predict_pte_update(input req_type r);
      rsp_type            o;
      logic [BLOCK_W-1:0] blk;
      logic [ENTRY_W-1:0] frame;
      int unsigned        idx;
      o     = '0;
      frame = {r.new_frame[ENTRY_W-1:PAGE_SHIFT], {FLAG_W{1'b0}}};
      blk   = r.entry[ENTRY_W-1:PAGE_SHIFT];
      case (r.cmd)
         CMD_SWAP_OUT: begin
            o.status = ST_FULL;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_is_free[i]) begin
                  slot_is_free[i]     = 1'b0;
                  slot_saved_flags[i] = r.entry[FLAG_W-1:0];
                  o.block_no  = BLOCK_W'(cfg_swap_base + i * BPP);
                  o.new_entry = {o.block_no, cfg_swapped_mark[FLAG_W-1:1], 1'b0};
                  o.action    = ACT_WRITE;
                  o.status    = ST_OK;
                  break;
               end
            end
         end
         CMD_FAULT, CMD_RELEASE: begin
            if (r.cmd == CMD_FAULT && r.entry[0]) begin
               o.new_entry = frame | {20'h0, PTE_PRESENT | PTE_WRITABLE};
               o.action    = ACT_COPY;
            end else begin
               o.block_no = blk;
               if (blk < cfg_swap_base || (blk - cfg_swap_base) / BPP >= SLOTS) begin
                  o.status = ST_RANGE;
               end else begin
                  idx = (blk - cfg_swap_base) / BPP;
                  if (r.cmd == CMD_FAULT) begin
                     o.new_entry = frame | {20'h0, slot_saved_flags[idx] | PTE_PRESENT};
                     o.action    = ACT_READ;
                  end
                  slot_is_free[idx] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // mostly well-formed traffic aimed at claimed slots, some noise at the edges
   function automatic req_type pick_request(input bit filling);
      req_type            r;
      int unsigned        roll;
      int unsigned        slot;
      logic [BLOCK_W-1:0] blk;
      r.cmd       = CMD_SWAP_OUT;
      r.entry     = $urandom;
      r.new_frame = $urandom;
      roll        = $urandom_range(99, 0);
      if (filling) roll = (roll < 92) ? 0 : 90;
      slot = $urandom_range(SLOTS - 1, 0);
      for (int k = 0; k < SLOTS && slot_is_free[slot]; k++) slot = (slot + 1) % SLOTS;
      blk = BLOCK_W'(cfg_swap_base + slot * BPP + $urandom_range(BPP - 1, 0));
      if (roll >= 90) begin
         r.cmd = cmd_type'($urandom_range(3, 0));
         case ($urandom_range(2, 0))
            0: r.entry[ENTRY_W-1:PAGE_SHIFT] = BLOCK_W'(cfg_swap_base - $urandom_range(4, 1));
            1: r.entry[ENTRY_W-1:PAGE_SHIFT] =
                  BLOCK_W'(cfg_swap_base + SLOTS * BPP - 4 + $urandom_range(7, 0));
            default: ;
         endcase
      end else if (roll >= 75) begin
         r.cmd = CMD_RELEASE;
         r.entry[ENTRY_W-1:PAGE_SHIFT] = blk;
      end else if (roll >= 65) begin
         r.cmd      = CMD_FAULT;
         r.entry[0] = 1'b1;
      end else if (roll >= 40) begin
         r.cmd   = CMD_FAULT;
         r.entry = {blk, r.entry[FLAG_W-1:1], 1'b0};
      end
      return r;
   endfunction

   task automatic send_request(input req_type r, output rsp_type pred);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pred = predict_pte_update(r);
      expected_pte_q.push_back(pred);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pte_q.size() != 0);
   endtask

   task automatic write_swap_config(input logic [BASE_W-1:0] base,
                                    input logic [BASE_W-1:0] mark);
      wait_drained();
      csr_index <= CSR_SWAP_BASE;
      csr_wdata <= base;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      cfg_swap_base = base;
      csr_index <= CSR_SWAPPED_MARK;
      csr_wdata <= mark;
      do @(posedge clock); while (!csr_ready);
      cfg_swapped_mark = mark[FLAG_W-1:0];
      csr_valid <= 1'b0;
   endtask

   function automatic void score_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pte_q.size() == 0) begin
               $display("%0t: result with none expected, got %p", $time, rsp_data);
               err_count++;
            end else begin
               oldest_pte = expected_pte_q.pop_front();
               score_field("new_entry", oldest_pte.new_entry, rsp_data.new_entry);
               score_field("block_no", 32'(oldest_pte.block_no), 32'(rsp_data.block_no));
               score_field("action", 32'(oldest_pte.action), 32'(rsp_data.action));
               score_field("status", 32'(oldest_pte.status), 32'(rsp_data.status));
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      rsp_type pred;
      int      full_seen;
      full_seen = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[k]) begin
         send_request(DIRECTED_ROWS[k].req, pred);
         if (DIRECTED_ROWS[k].check_typed)
            expected_pte_q[expected_pte_q.size() - 1] = DIRECTED_ROWS[k].rsp;
      end

      // fill the swap area until it has refused several swap-outs
      write_swap_config(16'h0000, 16'h0000);
      while (full_seen < FULL_TARGET) begin
         send_request(pick_request(1'b1), pred);
         if (pred.status == ST_FULL) full_seen++;
      end

      for (int p = 1; p < 6; p++) begin
         case (p)
            1: begin
               write_swap_config(16'hFFFF, 16'hFFFF);
               send_idle_pct = 67;
               rsp_stall_pct = 0;
            end
            2: begin
               write_swap_config(BASE_W'($urandom_range(65535, 0)),
                                 BASE_W'($urandom_range(65535, 0)));
               send_idle_pct = 0;
               rsp_stall_pct = 67;
            end
            3: begin
               write_swap_config(SWAP_BASE_RST, BASE_W'(SWAPPED_MARK_RST));
               send_idle_pct = 36;
               rsp_stall_pct = 36;
            end
            4: begin
               write_swap_config(BASE_W'($urandom_range(65535, 0)),
                                 BASE_W'($urandom_range(65535, 0)));
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            default: begin
               write_swap_config(16'h0000, 16'hFFFF);
               send_idle_pct = 36;
               rsp_stall_pct = 36;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 50 == 49) wait_drained();
            send_request(pick_request(1'b0), pred);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
